// ===== rtl/fire_effect_neighbour_average_core_macros.svh =====
// assertion macros for the fire effect core
`ifndef FIRE_EFFECT_NEIGHBOUR_AVERAGE_CORE_MACROS_SVH
`define FIRE_EFFECT_NEIGHBOUR_AVERAGE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must never hold outside reset
`define FENA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// same-cycle implication
`define FENA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FENA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FENA_ASSERT_NEVER(label, clk, rst, cond, msg)
`define FENA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define FENA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/fena_pkg.sv =====
package fena_pkg;

   localparam int PIXEL_W = 32;
   localparam int RGB_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int NUM_CH  = 3;
   localparam int SUM_W   = 10;
   localparam int CSR_W   = 11;
   localparam int CSR_IDX_W = 2;
   localparam int FADE_W  = 8;
   localparam int BOOST_W = 4;

   localparam logic [CSR_W-1:0] LINE_WIDTH_RST   = 11'd320;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RST = 11'd240;

   // floor(x / 3) == (x * 683) >> 11 for every x below 2048
   localparam logic [SUM_W-1:0] DIV3_RECIP = 10'd683;
   localparam int DIV3_SHIFT = 11;
   localparam int PROD_W = 22;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_FADE_AMOUNT  = 2'd2,
      CSR_WOBBLE_BOOST = 2'd3
   } csr_index_type;

   // sum of the neighbours that exist
   function automatic logic [SUM_W-1:0] chan_sum(input logic [CHAN_W-1:0] lft,
                                                 input logic [CHAN_W-1:0] rgt,
                                                 input logic [CHAN_W-1:0] blw,
                                                 input logic has_l,
                                                 input logic has_r,
                                                 input logic has_b);
      logic [SUM_W-1:0] s;
      s = '0;
      if (has_l) s = s + SUM_W'(lft);
      if (has_r) s = s + SUM_W'(rgt);
      if (has_b) s = s + SUM_W'(blw);
      return s;
   endfunction

   // truncating divide by neighbour count of one, two or three
   function automatic logic [CHAN_W-1:0] chan_quot(input logic [SUM_W-1:0] sum,
                                                   input logic [1:0] count);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(sum) * PROD_W'(DIV3_RECIP);
      case (count)
         2'd3:    return prod[DIV3_SHIFT +: CHAN_W];
         2'd2:    return sum[CHAN_W:1];
         default: return sum[CHAN_W-1:0];
      endcase
   endfunction

   // boost, fade, clamp at zero, keep low byte
   function automatic logic [CHAN_W-1:0] chan_fade(input logic [CHAN_W-1:0] quot,
                                                   input logic nonzero,
                                                   input logic [BOOST_W-1:0] boost,
                                                   input logic [FADE_W-1:0] fade);
      logic [SUM_W-1:0] v;
      logic [SUM_W-1:0] d;
      v = SUM_W'(quot) + (nonzero ? SUM_W'(boost) : '0);
      d = v - SUM_W'(fade);
      if (v < SUM_W'(fade)) return '0;
      return d[CHAN_W-1:0];
   endfunction

endpackage

// ===== rtl/fire_effect_neighbour_average_core.sv =====
// a result is registered in stage 1, in stage 2 and in the result queue before it appears on rsp_
// throughput: one item per cycle; the last item of a non-top row gives two results, and an
//   eight-entry result queue absorbs the extra one, so input stalls only when rsp_ backs up
// the line store is one single-port-read, single-write memory of MAX_WIDTH RGB entries
// reset: synchronous, clears counters, left/centre registers, queue and config to defaults;
//   the line store is not cleared and needs no clearing pass
`include "fire_effect_neighbour_average_core_macros.svh"

module fire_effect_neighbour_average_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fena_pkg::PIXEL_W-1:0]      req_in_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fena_pkg::PIXEL_W-1:0]      rsp_out_pixel,
   output logic [$clog2(MAX_WIDTH)-1:0]      rsp_out_column,
   output logic [$clog2(MAX_HEIGHT)-1:0]     rsp_out_row,
   output logic                              rsp_last_of_run,
   input  logic                              csr_wr_en,
   input  logic [fena_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fena_pkg::CSR_W-1:0]        csr_wdata
);
   import fena_pkg::*;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;
   localparam int LEVEL_W    = 5;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   row;
      logic               last;
   } rsp_entry_type;

   // configuration registers
   logic [CSR_W-1:0]   line_width_ff;
   logic [CSR_W-1:0]   frame_height_ff;
   logic [FADE_W-1:0]  fade_ff;
   logic [BOOST_W-1:0] boost_ff;

   // position and neighbour state
   logic [COL_W-1:0]   col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0]   row_cnt_ff, row_cnt_in;
   logic [RGB_W-1:0]   left_ff;
   logic [PIXEL_W-1:0] centre_ff;
   logic [RGB_W-1:0]   below_rd_ff;
   logic [RGB_W-1:0]   line_mem [MAX_WIDTH];

   // stage 1: operands of up to two results
   logic               s1_a_ff, s1_b_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff, s1_centre_ff;
   logic [RGB_W-1:0]   s1_left_ff, s1_below_ff;
   logic               s1_has_left_ff, s1_has_below_ff, s1_last_a_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;

   // stage 2: quotients
   logic               s2_a_ff, s2_b_ff;
   logic [CHAN_W-1:0]  s2_quot_a_ff [NUM_CH];
   logic [CHAN_W-1:0]  s2_quot_b_ff [NUM_CH];
   logic [NUM_CH-1:0]  s2_nz_a_ff, s2_nz_b_ff;
   logic [CHAN_W-1:0]  s2_alpha_a_ff, s2_alpha_b_ff;
   logic [COL_W-1:0]   s2_col_ff;
   logic [ROW_W-1:0]   s2_row_ff;
   logic               s2_last_a_ff;

   // result queue
   rsp_entry_type           fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;

   logic [COL_W-1:0]   last_col, col;
   logic [ROW_W-1:0]   last_row, out_row;
   logic               top, row_end, has_below, accept, emit_a, emit_b, pop;
   logic [LEVEL_W-1:0] level;
   logic [SUM_W-1:0]   sum_a [NUM_CH];
   logic [SUM_W-1:0]   sum_b [NUM_CH];
   logic [CHAN_W-1:0]  quot_a [NUM_CH];
   logic [CHAN_W-1:0]  quot_b [NUM_CH];
   logic [1:0]         cnt_a, cnt_b;
   rsp_entry_type      entry_a, entry_b;

   // saturated geometry
   always_comb begin
      if (line_width_ff < CSR_W'(2)) begin
         last_col = COL_W'(1);
      end else if (32'(line_width_ff) > 32'(MAX_WIDTH)) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(line_width_ff - CSR_W'(1));
      end
      if (frame_height_ff < CSR_W'(2)) begin
         last_row = ROW_W'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         last_row = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         last_row = ROW_W'(frame_height_ff - CSR_W'(1));
      end
   end

   // position of the incoming item
   always_comb begin
      col       = (col_cnt_ff >= last_col) ? last_col : col_cnt_ff;
      top       = row_cnt_ff >= last_row;
      row_end   = col == last_col;
      has_below = row_cnt_ff != '0;
      out_row   = top ? '0 : last_row - row_cnt_ff;
      accept    = req_valid && req_ready;
      emit_a    = accept && (col != '0) && !top;
      emit_b    = accept && row_end && !top;
      if (row_end) begin
         col_cnt_in = '0;
         row_cnt_in = top ? '0 : row_cnt_ff + ROW_W'(1);
      end else begin
         col_cnt_in = col + COL_W'(1);
         row_cnt_in = row_cnt_ff;
      end
   end

   // room for everything in flight plus two more results
   assign level = LEVEL_W'(count_ff) + LEVEL_W'(s1_a_ff) + LEVEL_W'(s1_b_ff)
                + LEVEL_W'(s2_a_ff) + LEVEL_W'(s2_b_ff);
   assign req_ready = level <= LEVEL_W'(FIFO_DEPTH - 2);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         fade_ff         <= '0;
         boost_ff        <= '0;
         col_cnt_ff      <= '0;
         row_cnt_ff      <= '0;
         left_ff         <= '0;
         centre_ff       <= '0;
         s1_a_ff         <= 1'b0;
         s1_b_ff         <= 1'b0;
         s2_a_ff         <= 1'b0;
         s2_b_ff         <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
               CSR_FADE_AMOUNT:  fade_ff         <= csr_wdata[FADE_W-1:0];
               CSR_WOBBLE_BOOST: boost_ff        <= csr_wdata[BOOST_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
            centre_ff  <= req_in_pixel;
            if (col != '0) left_ff <= centre_ff[RGB_W-1:0];
         end
         s1_a_ff <= emit_a;
         s1_b_ff <= emit_b;
         s2_a_ff <= s1_a_ff;
         s2_b_ff <= s1_b_ff;
      end
   end

   // line store: read old row below, write this pixel in its place
   always_ff @(posedge clock) begin
      if (accept) begin
         below_rd_ff   <= line_mem[col];
         line_mem[col] <= req_in_pixel[RGB_W-1:0];
      end
   end

   // stage 1 operand capture
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff     <= req_in_pixel;
         s1_centre_ff    <= centre_ff;
         s1_left_ff      <= left_ff;
         s1_below_ff     <= below_rd_ff;
         s1_has_left_ff  <= col > COL_W'(1);
         s1_has_below_ff <= has_below;
         s1_last_a_ff    <= !row_end;
         s1_col_ff       <= col;
         s1_row_ff       <= out_row;
      end
   end

   // stage 1: neighbour sums and quotients; the second result sees the row
   // below of this item, which the line store presents now
   always_comb begin
      cnt_a = {1'b0, s1_has_left_ff} + 2'd1 + {1'b0, s1_has_below_ff};
      cnt_b = 2'd1 + {1'b0, s1_has_below_ff};
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum_a[ch]  = chan_sum(s1_left_ff[ch*CHAN_W +: CHAN_W],
                               s1_pixel_ff[ch*CHAN_W +: CHAN_W],
                               s1_below_ff[ch*CHAN_W +: CHAN_W],
                               s1_has_left_ff, 1'b1, s1_has_below_ff);
         sum_b[ch]  = chan_sum(s1_centre_ff[ch*CHAN_W +: CHAN_W],
                               '0,
                               below_rd_ff[ch*CHAN_W +: CHAN_W],
                               1'b1, 1'b0, s1_has_below_ff);
         quot_a[ch] = chan_quot(sum_a[ch], cnt_a);
         quot_b[ch] = chan_quot(sum_b[ch], cnt_b);
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s2_quot_a_ff[ch] <= quot_a[ch];
         s2_quot_b_ff[ch] <= quot_b[ch];
         s2_nz_a_ff[ch]   <= sum_a[ch] != '0;
         s2_nz_b_ff[ch]   <= sum_b[ch] != '0;
      end
      s2_alpha_a_ff <= s1_centre_ff[PIXEL_W-1 -: CHAN_W];
      s2_alpha_b_ff <= s1_pixel_ff[PIXEL_W-1 -: CHAN_W];
      s2_col_ff     <= s1_col_ff;
      s2_row_ff     <= s1_row_ff;
      s2_last_a_ff  <= s1_last_a_ff;
   end

   // stage 2: boost, fade and clamp
   always_comb begin
      entry_a.pixel[PIXEL_W-1 -: CHAN_W] = s2_alpha_a_ff;
      entry_b.pixel[PIXEL_W-1 -: CHAN_W] = s2_alpha_b_ff;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         entry_a.pixel[ch*CHAN_W +: CHAN_W] =
            chan_fade(s2_quot_a_ff[ch], s2_nz_a_ff[ch], boost_ff, fade_ff);
         entry_b.pixel[ch*CHAN_W +: CHAN_W] =
            chan_fade(s2_quot_b_ff[ch], s2_nz_b_ff[ch], boost_ff, fade_ff);
      end
      entry_a.column = s2_col_ff - COL_W'(1);
      entry_a.row    = s2_row_ff;
      entry_a.last   = s2_last_a_ff;
      entry_b.column = s2_col_ff;
      entry_b.row    = s2_row_ff;
      entry_b.last   = 1'b1;
   end

   // result queue
   assign rsp_valid       = count_ff != '0;
   assign pop             = rsp_valid && rsp_ready;
   assign rsp_out_pixel   = fifo_mem_ff[rd_ptr_ff].pixel;
   assign rsp_out_column  = fifo_mem_ff[rd_ptr_ff].column;
   assign rsp_out_row     = fifo_mem_ff[rd_ptr_ff].row;
   assign rsp_last_of_run = fifo_mem_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (s2_a_ff) fifo_mem_ff[wr_ptr_ff] <= entry_a;
      if (s2_b_ff) fifo_mem_ff[wr_ptr_ff + FIFO_PTR_W'(s2_a_ff)] <= entry_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(s2_a_ff) + FIFO_PTR_W'(s2_b_ff);
         rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(pop);
         count_ff  <= count_ff + FIFO_CNT_W'(s2_a_ff) + FIFO_CNT_W'(s2_b_ff)
                    - FIFO_CNT_W'(pop);
      end
   end

   // checks
   `FENA_ASSERT_NEVER(a_fifo_overflow, clock, reset, count_ff > FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
   `FENA_ASSERT_IMPLY(a_row_end_col, clock, reset, s1_b_ff, s1_col_ff != '0, "row end result at column zero")
   `FENA_ASSERT_IMPLY(a_pair_order, clock, reset, s1_a_ff && s1_b_ff, !s1_last_a_ff, "first of two results marked last")
   `FENA_ASSERT_NEXT(a_pop_count, clock, reset, pop && !s2_a_ff && !s2_b_ff, count_ff == $past(count_ff) - FIFO_CNT_W'(1), "queue count wrong after pop")

endmodule
